// File: rtl/pidaw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types and constants of the PID controller with clamped integrator.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int DATA_W = 16;
    localparam int IDX_W  = 3;
    localparam int ACC_W  = 35;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DRIVE_MAX = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DRIVE_MIN = 3'd4;

    // integrator limits
    localparam logic signed [DATA_W:0] SUM_HI = 17'sd32000;
    localparam logic signed [DATA_W:0] SUM_LO = -17'sd32000;

    localparam logic signed [DATA_W-1:0] DRIVE_MAX_RST = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] DRIVE_MIN_RST = 16'sh8000;

    typedef enum logic [1:0] {
        LIMIT_NONE = 2'd0,
        LIMIT_MAX  = 2'd1,
        LIMIT_MIN  = 2'd2
    } t_limit;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] drive_max;
        logic signed [DATA_W-1:0] drive_min;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        t_limit                   limit_hit;
    } t_result;

endpackage

// File: rtl/pidaw_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_cfg_regs
// Gain and output limit registers, written through the configuration port.
// ----------------------------------------------------------------------------
module pidaw_cfg_regs
    import pidaw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // every write completes at once
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN_P:    n_cfg.gain_p    = i_cfg_data;
                CFG_GAIN_I:    n_cfg.gain_i    = i_cfg_data;
                CFG_GAIN_D:    n_cfg.gain_d    = i_cfg_data;
                CFG_DRIVE_MAX: n_cfg.drive_max = i_cfg_data;
                CFG_DRIVE_MIN: n_cfg.drive_min = i_cfg_data;
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p    <= '0;
            r_cfg.gain_i    <= '0;
            r_cfg.gain_d    <= '0;
            r_cfg.drive_max <= DRIVE_MAX_RST;
            r_cfg.drive_min <= DRIVE_MIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/pidaw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_core
// One control step: error, clamped integrator, three products, limit check
// and integrator back-off. Holds the integral sum and the previous error.
// ----------------------------------------------------------------------------
module pidaw_core
    import pidaw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic signed [DATA_W-1:0] i_measured,
    input  t_cfg                     i_cfg,
    output t_result                  o_result
);

    logic signed [DATA_W-1:0] r_sum;
    logic signed [DATA_W-1:0] r_prev_err;
    logic signed [DATA_W-1:0] n_sum;

    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W:0]   sum_raw;
    logic signed [DATA_W-1:0] sum_clamped;
    logic signed [DATA_W:0]   diff;
    logic signed [31:0]       prod_p;
    logic signed [31:0]       prod_i;
    logic signed [32:0]       prod_d;
    logic signed [ACC_W-1:0]  acc;
    logic signed [DATA_W:0]   max_m1;
    logic signed [ACC_W-1:0]  hi_thr;
    logic signed [ACC_W-1:0]  lo_thr;
    logic                     round_up;
    logic signed [DATA_W-1:0] quot;

    assign err     = i_target - i_measured;
    assign sum_raw = {r_sum[DATA_W-1], r_sum} + {err[DATA_W-1], err};

    always_comb begin
        if (sum_raw > SUM_HI) begin
            sum_clamped = SUM_HI[DATA_W-1:0];
        end else if (sum_raw < SUM_LO) begin
            sum_clamped = SUM_LO[DATA_W-1:0];
        end else begin
            sum_clamped = sum_raw[DATA_W-1:0];
        end
    end

    assign diff   = {err[DATA_W-1], err} - {r_prev_err[DATA_W-1], r_prev_err};
    assign prod_p = i_cfg.gain_p * err;
    assign prod_i = i_cfg.gain_i * sum_clamped;
    assign prod_d = i_cfg.gain_d * diff;

    assign acc = {{3{prod_p[31]}}, prod_p} + {{3{prod_i[31]}}, prod_i}
               + {{2{prod_d[32]}}, prod_d};

    // limits in Q.8
    assign max_m1 = {i_cfg.drive_max[DATA_W-1], i_cfg.drive_max} - 17'sd1;
    assign hi_thr = {{10{max_m1[DATA_W]}}, max_m1, 8'h00};
    assign lo_thr = {{11{i_cfg.drive_min[DATA_W-1]}}, i_cfg.drive_min, 8'h00};

    // truncate toward zero: negative values with a fraction move up by one
    assign round_up = acc[ACC_W-1] & (|acc[7:0]);
    assign quot     = acc[23:8] + {{(DATA_W-1){1'b0}}, round_up};

    always_comb begin
        n_sum = sum_clamped;
        if (acc >= hi_thr) begin
            o_result.drive     = i_cfg.drive_max;
            o_result.limit_hit = LIMIT_MAX;
            // drop a step that pushed further into the upper limit
            if (sum_clamped > r_sum) begin
                n_sum = r_sum;
            end
        end else if (acc <= lo_thr) begin
            o_result.drive     = i_cfg.drive_min;
            o_result.limit_hit = LIMIT_MIN;
            if (sum_clamped < r_sum) begin
                n_sum = r_sum;
            end
        end else begin
            o_result.drive     = quot;
            o_result.limit_hit = LIMIT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_prev_err <= '0;
        end else if (i_step) begin
            r_sum      <= n_sum;
            r_prev_err <= err;
        end
    end

endmodule

// File: rtl/pid_antiwindup_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_antiwindup_controller
// PID controller with a clamped integrator and anti-windup back-off.
// ----------------------------------------------------------------------------
// Input channel: i_target and i_measured, a transaction at each edge with
// i_in_valid high and o_in_stall low. Output channel: o_drive and
// o_limit_hit, a transaction at each edge with o_out_valid high and
// i_out_stall low. Configuration: i_cfg_index / i_cfg_data with
// i_cfg_valid, o_cfg_ready is always high; write only while idle.
// An item waits in the input register, the control step runs in one pass
// of combinational logic, and the result is captured in the output
// register, from which it leaves when the receiver does not stall.
// Throughput is one item per cycle while the receiver does not stall, set
// by the update of the integral sum and previous error that each step
// leaves for the next.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more item; after that o_in_stall rises.
// Synchronous reset clears both registers' valid flags, the integral sum
// and previous error, zeroes the gains and opens the limits to full range.
// ----------------------------------------------------------------------------
module pid_antiwindup_controller
    import pidaw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic signed [DATA_W-1:0] i_measured,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_drive,
    output logic [1:0]               o_limit_hit,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    t_cfg    cfg;
    t_result result;

    logic                     r_in_valid;
    logic signed [DATA_W-1:0] r_target;
    logic signed [DATA_W-1:0] r_measured;
    logic                     r_out_valid;
    t_result                  r_out;
    logic                     advance;
    logic                     in_take;

    pidaw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // output register free, or emptied this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    pidaw_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (r_in_valid && advance),
        .i_target   (r_target),
        .i_measured (r_measured),
        .i_cfg      (cfg),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_in_valid || advance) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_target   <= i_target;
            r_measured <= i_measured;
        end
        if (advance && r_in_valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out.drive;
    assign o_limit_hit = r_out.limit_hit;

endmodule

// File: rtl/pidaw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_checker
// Port-level checks of the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidaw_checker
    import pidaw_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DATA_W-1:0] o_drive,
    input logic [1:0]        o_limit_hit
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive)
            && $stable(o_limit_hit))
        else $error("stalled result changed");

    // the input side only stalls behind a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // an accepted item passes the input register and reaches the output when nothing stalls
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_out_stall) ##1 !i_out_stall
            |=> o_out_valid)
        else $error("result not delivered after two cycles");

    // no result is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_flag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_limit_hit != 2'b11)
        else $error("undefined limit flag");

endmodule

bind pid_antiwindup_controller pidaw_checker u_pidaw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive     (o_drive),
    .o_limit_hit (o_limit_hit)
);

// File: tb/pidaw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_scoreboard
// Watches the sample, result and register channels of the PID controller,
// keeps its own copy of the gains, limits, integral sum and last error, works
// out the drive for every accepted sample and compares it, field by field,
// with the results that leave the block in order.
// ----------------------------------------------------------------------------
module pidaw_scoreboard
    import pidaw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic signed [DATA_W-1:0] i_measured,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [DATA_W-1:0] i_drive,
    input  logic [1:0]               i_limit_hit,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    t_cfg                     loop_regs;
    logic signed [DATA_W-1:0] integ_sum;
    logic signed [DATA_W-1:0] prev_err;
    t_result                  drive_exp_q[$];
    t_result                  oldest;

    // One control step: error, clamped integrator, PID sum, output limits and
    // integrator back-off when the step drives further into the limit hit.
    function automatic t_result control_step(input logic signed [DATA_W-1:0] tgt,
                                             input logic signed [DATA_W-1:0] meas);
        logic signed [DATA_W-1:0] err;
        int                       old_sum;
        int                       new_sum;
        longint                   acc;
        longint                   upper;
        longint                   lower;
        longint                   quot;
        t_result                  r;
        err     = tgt - meas;
        old_sum = int'(integ_sum);
        new_sum = old_sum + int'(err);
        if (new_sum > int'(SUM_HI)) new_sum = int'(SUM_HI);
        if (new_sum < int'(SUM_LO)) new_sum = int'(SUM_LO);
        acc = longint'(loop_regs.gain_p) * longint'(err)
            + longint'(loop_regs.gain_i) * longint'(new_sum)
            + longint'(loop_regs.gain_d) * (longint'(err) - longint'(prev_err));
        upper = (longint'(loop_regs.drive_max) - 1) * 256;
        lower = longint'(loop_regs.drive_min) * 256;
        if (acc >= upper) begin
            r.drive     = loop_regs.drive_max;
            r.limit_hit = LIMIT_MAX;
            if (new_sum > old_sum) new_sum = old_sum;
        end else if (acc <= lower) begin
            r.drive     = loop_regs.drive_min;
            r.limit_hit = LIMIT_MIN;
            if (new_sum < old_sum) new_sum = old_sum;
        end else begin
            quot        = acc / 256;
            r.drive     = quot[DATA_W-1:0];
            r.limit_hit = LIMIT_NONE;
        end
        integ_sum = DATA_W'(new_sum);
        prev_err  = err;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            loop_regs.gain_p    = '0;
            loop_regs.gain_i    = '0;
            loop_regs.gain_d    = '0;
            loop_regs.drive_max = DRIVE_MAX_RST;
            loop_regs.drive_min = DRIVE_MIN_RST;
            integ_sum           = '0;
            prev_err            = '0;
            drive_exp_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GAIN_P:    loop_regs.gain_p    = i_cfg_data;
                    CFG_GAIN_I:    loop_regs.gain_i    = i_cfg_data;
                    CFG_GAIN_D:    loop_regs.gain_d    = i_cfg_data;
                    CFG_DRIVE_MAX: loop_regs.drive_max = i_cfg_data;
                    CFG_DRIVE_MIN: loop_regs.drive_min = i_cfg_data;
                    default: ;
                endcase
            end
            // compare before pushing: a sample taken now cannot leave this cycle
            if (i_out_valid && !i_out_stall) begin
                if (drive_exp_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, got drive %0d limit_hit %0d",
                             $time, i_drive, i_limit_hit);
                end else begin
                    oldest = drive_exp_q.pop_front();
                    if (i_drive !== oldest.drive) begin
                        o_fail_count++;
                        $display("%0t: drive expected %0d, got %0d",
                                 $time, oldest.drive, i_drive);
                    end
                    if (i_limit_hit !== oldest.limit_hit) begin
                        o_fail_count++;
                        $display("%0t: limit_hit expected %0d, got %0d",
                                 $time, oldest.limit_hit, i_limit_hit);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                drive_exp_q.push_back(control_step(i_target, i_measured));
        end
        o_pending = drive_exp_q.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the PID controller with clamped integrator: a
// directed run over error wrap, truncation, integrator saturation, both
// output clamps with back-off and crossed limits, then randomised phases of
// gains and limits with setpoint tracking, windup pushes and noise samples,
// under random sample gaps and result stalls, save in the calm last phase.
// ----------------------------------------------------------------------------
module tb_top;
    import pidaw_pkg::*;

    localparam int               RANDOM_ITEMS  = 850;
    localparam int               RANDOM_PHASES = 10;
    // index with no register behind it
    localparam logic [IDX_W-1:0] CFG_SPARE     = 3'd7;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] target     = '0;
    logic signed [DATA_W-1:0] measured   = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic signed [DATA_W-1:0] drive;
    logic [1:0]               limit_hit;
    logic                     cfg_valid  = 1'b0;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index  = '0;
    logic [DATA_W-1:0]        cfg_data   = '0;
    int                       fail_count;
    int                       pending;
    bit                       calm       = 1'b0;
    int                       stall_left = 0;

    pid_antiwindup_controller DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_target    (target),
        .i_measured  (measured),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_drive     (drive),
        .o_limit_hit (limit_hit),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pidaw_scoreboard u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_target     (target),
        .i_measured   (measured),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_drive      (drive),
        .i_limit_hit  (limit_hit),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: stall in bursts of random length
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_sample(input logic signed [DATA_W-1:0] tgt,
                               input logic signed [DATA_W-1:0] meas);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        target   <= tgt;
        measured <= meas;
        do @(posedge clk); while (in_stall);
    endtask

    // drop valid and let every outstanding result come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input t_cfg c);
        write_reg(CFG_GAIN_P, c.gain_p);
        write_reg(CFG_GAIN_I, c.gain_i);
        write_reg(CFG_GAIN_D, c.gain_d);
        write_reg(CFG_DRIVE_MAX, c.drive_max);
        write_reg(CFG_DRIVE_MIN, c.drive_min);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_cfg make_settings(input logic signed [DATA_W-1:0] gp,
                                           input logic signed [DATA_W-1:0] gi,
                                           input logic signed [DATA_W-1:0] gd,
                                           input logic signed [DATA_W-1:0] dmax,
                                           input logic signed [DATA_W-1:0] dmin);
        t_cfg c;
        c.gain_p    = gp;
        c.gain_i    = gi;
        c.gain_d    = gd;
        c.drive_max = dmax;
        c.drive_min = dmin;
        return c;
    endfunction

    // mostly modest gains, now and then the whole range; limits full, symmetric,
    // a narrow window or anything at all, crossed ones included
    function automatic t_cfg pick_settings();
        t_cfg c;
        int   span;
        if ($urandom_range(0, 3) == 0) begin
            c.gain_p = DATA_W'($urandom);
            c.gain_i = DATA_W'($urandom);
            c.gain_d = DATA_W'($urandom);
        end else begin
            c.gain_p = DATA_W'(int'($urandom_range(0, 1024)) - 512);
            c.gain_i = DATA_W'(int'($urandom_range(0, 256)) - 128);
            c.gain_d = DATA_W'(int'($urandom_range(0, 1024)) - 512);
        end
        case ($urandom_range(0, 3))
            0: begin
                c.drive_max = DRIVE_MAX_RST;
                c.drive_min = DRIVE_MIN_RST;
            end
            1: begin
                span        = $urandom_range(1, 20000);
                c.drive_max = DATA_W'(span);
                c.drive_min = DATA_W'(-span);
            end
            2: begin
                c.drive_max = DATA_W'($urandom);
                c.drive_min = DATA_W'($urandom);
            end
            default: begin
                span        = $urandom_range(0, 3000);
                c.drive_min = DATA_W'(int'($urandom_range(0, 40000)) - 20000);
                c.drive_max = DATA_W'(int'(c.drive_min) + span);
            end
        endcase
        return c;
    endfunction

    initial begin
        int                       pick;
        int                       push;
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] meas;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset gains are zero: drive stays at zero, error wraps at the extremes
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh0000, 16'sh0000);
        drain();

        // fractional gains: truncation toward zero, integrator saturation both ways
        apply_settings(make_settings(16'sh0080, 16'sh0001, 16'shFFE0,
                                     DRIVE_MAX_RST, DRIVE_MIN_RST));
        write_reg(CFG_SPARE, 16'hFFFF);
        @(negedge clk);
        cfg_valid <= 1'b0;
        send_sample(-16'sd3, 16'sd0);
        send_sample(16'sd5, 16'sd0);
        send_sample(16'sh7FFF, 16'sd0);
        send_sample(16'sh7FFF, 16'sd0);
        send_sample(16'sh8000, 16'sd0);
        send_sample(16'sh8000, 16'sd0);
        send_sample(16'sh8000, 16'sd0);
        send_sample(16'sh7FFF, 16'sh8000);
        drain();

        // narrow limits: both clamps with back-off, upper threshold at its edge
        apply_settings(make_settings(16'sh0100, 16'sh0100, 16'sh0000, 16'sd1000, -16'sd1000));
        send_sample(16'sd2000, 16'sd0);
        send_sample(-16'sd2000, 16'sd0);
        send_sample(16'sd500, 16'sd0);
        send_sample(16'sd499, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        drain();

        // crossed limits: the upper test wins, else the lower one
        apply_settings(make_settings(16'sh0100, 16'sh0000, 16'sh0000, -16'sd100, 16'sd100));
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd20000, 16'sd0);
        drain();

        // extreme gains
        apply_settings(make_settings(16'sh8000, 16'sh7FFF, 16'sh8000,
                                     DRIVE_MAX_RST, DRIVE_MIN_RST));
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sd0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            apply_settings(pick_settings());
            if (phase == RANDOM_PHASES - 1) begin
                @(posedge clk);
                calm = 1'b1;
            end
            setpoint = DATA_W'($urandom);
            push     = int'($urandom_range(2000, 30000));
            if ($urandom_range(0, 1) == 1) push = -push;
            for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
                pick = $urandom_range(0, 9);
                if (pick == 9) setpoint = DATA_W'($urandom);
                if (pick < 6 || pick == 9) begin
                    meas = DATA_W'(int'(setpoint) + int'($urandom_range(0, 400)) - 200);
                    send_sample(setpoint, meas);
                end else if (pick < 8) begin
                    // hold a large error to wind the integrator into a limit
                    meas = DATA_W'(int'(setpoint) + push);
                    send_sample(setpoint, meas);
                end else begin
                    send_sample(DATA_W'($urandom), DATA_W'($urandom));
                end
            end
            drain();
        end

        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: pid_antiwindup_controller.f
rtl/pidaw_pkg.sv
rtl/pidaw_cfg_regs.sv
rtl/pidaw_core.sv
rtl/pid_antiwindup_controller.sv
rtl/pidaw_checker.sv
tb/pidaw_checker.sv
tb/tb_top.sv
